// ----- src/tzp_pkg.sv -----
// ----------------------------------------------------------------------------
// tzp_pkg: shared types and constants of the torus point plotter
// Command codes, controller states, datapath steps and the shade ramp.
// ----------------------------------------------------------------------------
package tzp_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 22;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PLOT  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam int         DIV_STEPS  = 16;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_PLOT,
    S_READW,
    S_RESP
  } ctl_state_e;

  // one entry per datapath step of a plot; P_DIV is held for every divider iteration
  typedef enum logic [4:0] {
    P_NONE,
    P_CH, P_CHE, P_CHG, P_FG, P_FE, P_DEN,
    P_LH, P_LHM, P_LHN, P_TN, P_TM, P_PXY,
    P_CD, P_CDG, P_CDE, P_LD, P_LDN, P_A, P_AM, P_LUM, P_LUMC,
    P_DIVI, P_DIV,
    P_PXD, P_PYD, P_XY, P_RD, P_WR
  } pstep_e;

  typedef struct packed {
    logic   capture;
    logic   clr_en;
    logic   rd_cell;
    logic   take_cell;
    logic   load_out;
    pstep_e step;
  } tzp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       clr_last;
  } tzp_stat_t;

  function automatic logic [7:0] ramp_char(input logic [3:0] lum);
    logic [7:0] ch;
    case (lum)
      4'd0:    ch = 8'h2E;
      4'd1:    ch = 8'h2C;
      4'd2:    ch = 8'h2D;
      4'd3:    ch = 8'h7E;
      4'd4:    ch = 8'h3A;
      4'd5:    ch = 8'h3B;
      4'd6:    ch = 8'h3D;
      4'd7:    ch = 8'h21;
      4'd8:    ch = 8'h2A;
      4'd9:    ch = 8'h23;
      4'd10:   ch = 8'h24;
      default: ch = 8'h40;
    endcase
    return ch;
  endfunction

endpackage

// ----- src/tzp_if.sv -----
// ----------------------------------------------------------------------------
// tzp_in_if / tzp_out_if: item channels of the torus point plotter
// Valid/ready channels carrying one command item or one result item.
// ----------------------------------------------------------------------------
interface tzp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] sin_theta;
  logic signed [15:0] cos_theta;
  logic signed [15:0] sin_phi;
  logic signed [15:0] cos_phi;
  logic signed [15:0] sin_rot_a;
  logic signed [15:0] cos_rot_a;
  logic signed [15:0] sin_rot_b;
  logic signed [15:0] cos_rot_b;
  logic [10:0]        cell_index;

  modport source (output valid, command, sin_theta, cos_theta, sin_phi, cos_phi,
                  sin_rot_a, cos_rot_a, sin_rot_b, cos_rot_b, cell_index,
                  input ready);
  modport sink   (input valid, command, sin_theta, cos_theta, sin_phi, cos_phi,
                  sin_rot_a, cos_rot_a, sin_rot_b, cos_rot_b, cell_index,
                  output ready);
endinterface

interface tzp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic       point_written;

  modport source (output valid, cell_char, point_written, input ready);
  modport sink   (input valid, cell_char, point_written, output ready);
endinterface

// ----- src/tzp_controller.sv -----
// ----------------------------------------------------------------------------
// tzp_controller: sequencer of the torus point plotter
// Runs clear sweeps, the plot step list, cell reads and the output handshake.
// ----------------------------------------------------------------------------
module tzp_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  tzp_pkg::tzp_stat_t  stat_i,
  output tzp_pkg::tzp_cmd_t   cmd_o
);

  tzp_pkg::ctl_state_e state_q, state_d;
  tzp_pkg::pstep_e     step_q, step_d;
  logic [3:0]          div_q, div_d;
  logic                clr_resp_q, clr_resp_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tzp_pkg::S_CLEAR;
      step_q      <= tzp_pkg::P_NONE;
      div_q       <= '0;
      clr_resp_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      div_q       <= div_d;
      clr_resp_q  <= clr_resp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    div_d      = div_q;
    clr_resp_d = clr_resp_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tzp_pkg::S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_last) begin
          state_d    = clr_resp_q ? tzp_pkg::S_RESP : tzp_pkg::S_IDLE;
          clr_resp_d = 1'b0;
        end
      end
      tzp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = tzp_pkg::S_DISPATCH;
        end
      end
      tzp_pkg::S_DISPATCH: begin
        case (stat_i.cmd)
          tzp_pkg::CMD_CLEAR: begin
            clr_resp_d = 1'b1;
            state_d    = tzp_pkg::S_CLEAR;
          end
          tzp_pkg::CMD_PLOT: begin
            step_d  = tzp_pkg::P_CH;
            div_d   = '0;
            state_d = tzp_pkg::S_PLOT;
          end
          tzp_pkg::CMD_READ: begin
            cmd_o.rd_cell = 1'b1;
            state_d       = tzp_pkg::S_READW;
          end
          default: state_d = tzp_pkg::S_RESP;
        endcase
      end
      tzp_pkg::S_PLOT: begin
        cmd_o.step = step_q;
        if (step_q == tzp_pkg::P_DIV) begin
          div_d = div_q + 4'd1;
          if (div_q == 4'(tzp_pkg::DIV_STEPS - 1)) begin
            step_d = tzp_pkg::pstep_e'(step_q + 5'd1);
          end
        end else if (step_q == tzp_pkg::P_WR) begin
          step_d  = tzp_pkg::P_NONE;
          state_d = tzp_pkg::S_RESP;
        end else begin
          step_d = tzp_pkg::pstep_e'(step_q + 5'd1);
        end
      end
      tzp_pkg::S_READW: begin
        cmd_o.take_cell = 1'b1;
        state_d         = tzp_pkg::S_RESP;
      end
      tzp_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = tzp_pkg::S_IDLE;
        end
      end
      default: state_d = tzp_pkg::S_IDLE;
    endcase
    out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/tzp_datapath.sv -----
// ----------------------------------------------------------------------------
// tzp_datapath: arithmetic and frame memory of the torus point plotter
// One shared multiplier, a radix-2 reciprocal divider and the cell memory.
// ----------------------------------------------------------------------------
module tzp_datapath #(
  parameter int COLUMNS = tzp_pkg::COLUMNS_DEF,
  parameter int ROWS    = tzp_pkg::ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tzp_pkg::tzp_cmd_t  cmd_i,
  output tzp_pkg::tzp_stat_t stat_o,
  input  logic [1:0]         command_i,
  input  logic signed [15:0] sin_theta_i,
  input  logic signed [15:0] cos_theta_i,
  input  logic signed [15:0] sin_phi_i,
  input  logic signed [15:0] cos_phi_i,
  input  logic signed [15:0] sin_rot_a_i,
  input  logic signed [15:0] cos_rot_a_i,
  input  logic signed [15:0] sin_rot_b_i,
  input  logic signed [15:0] cos_rot_b_i,
  input  logic [10:0]        cell_index_i,
  output logic [7:0]         cell_char_o,
  output logic               point_written_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int REM_W = 49;

  localparam logic signed [63:0] BIAS28 = (64'sd1 <<< 28) - 64'sd1;
  localparam logic signed [63:0] BIAS44 = (64'sd1 <<< 44) - 64'sd1;
  localparam logic signed [63:0] BIAS53 = (64'sd1 <<< 53) - 64'sd1;
  localparam logic signed [47:0] DEN_OFS = 48'sd5 <<< 42;
  localparam logic signed [47:0] SAT_LIM = 48'sd1 <<< 42;

  // captured item
  logic [1:0]         cmd_q;
  logic signed [15:0] c_q, l_q, f_q, d_q, e_q, g_q, n_q, m_q;
  logic [10:0]        idx_q;

  // products and partial sums
  logic signed [31:0] ch_q, fg_q, fe_q, lh_q, cd_q, ld_q;
  logic signed [47:0] che_q, chg_q, lhm_q, lhn_q, cdg_q, cde_q, ldn_q;
  logic signed [47:0] den_q, t_q, av_q;
  logic signed [63:0] tn_q, tm_q, am_q, lsum_q;
  logic signed [37:0] px_q, py_q;
  logic signed [55:0] pxd_q, pyd_q;
  logic signed [15:0] x_q, y_q;
  logic [3:0]         lum_q;

  // divider
  logic [REM_W-1:0]   rem_q, r2, den_u;
  logic [15:0]        q_q, dv;
  logic               sat_q, den_pos_q;

  // memory side
  logic [23:0]        mem [CELLS];
  logic [23:0]        rd_q;
  logic [AW-1:0]      clr_addr_q, o_q, o_comb, rd_addr;
  logic               inb_q, rd_en, wr_en;
  logic [7:0]         res_char_q, out_char_q;
  logic               res_wr_q, out_wr_q;

  logic signed [17:0] h;
  logic signed [47:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] prod;
  logic signed [63:0] pxs, pys, xs, ys, lsum, lq;
  logic signed [37:0] px_cut, py_cut;
  logic signed [15:0] x_cut, y_cut;
  logic               x_ok, y_ok;

  assign h = 18'(d_q) + 18'sd32768;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      tzp_pkg::P_CH:  begin mul_a = 48'(c_q);   mul_b = h;          end
      tzp_pkg::P_CHE: begin mul_a = 48'(ch_q);  mul_b = 18'(e_q);   end
      tzp_pkg::P_CHG: begin mul_a = 48'(ch_q);  mul_b = 18'(g_q);   end
      tzp_pkg::P_FG:  begin mul_a = 48'(f_q);   mul_b = 18'(g_q);   end
      tzp_pkg::P_FE:  begin mul_a = 48'(f_q);   mul_b = 18'(e_q);   end
      tzp_pkg::P_LH:  begin mul_a = 48'(l_q);   mul_b = h;          end
      tzp_pkg::P_LHM: begin mul_a = 48'(lh_q);  mul_b = 18'(m_q);   end
      tzp_pkg::P_LHN: begin mul_a = 48'(lh_q);  mul_b = 18'(n_q);   end
      tzp_pkg::P_TN:  begin mul_a = t_q;        mul_b = 18'(n_q);   end
      tzp_pkg::P_TM:  begin mul_a = t_q;        mul_b = 18'(m_q);   end
      tzp_pkg::P_CD:  begin mul_a = 48'(c_q);   mul_b = 18'(d_q);   end
      tzp_pkg::P_CDG: begin mul_a = 48'(cd_q);  mul_b = 18'(g_q);   end
      tzp_pkg::P_CDE: begin mul_a = 48'(cd_q);  mul_b = 18'(e_q);   end
      tzp_pkg::P_LD:  begin mul_a = 48'(l_q);   mul_b = 18'(d_q);   end
      tzp_pkg::P_LDN: begin mul_a = 48'(ld_q);  mul_b = 18'(n_q);   end
      tzp_pkg::P_AM:  begin mul_a = av_q;       mul_b = 18'(m_q);   end
      tzp_pkg::P_PXD: begin mul_a = 48'(px_q);  mul_b = {2'b00, dv}; end
      tzp_pkg::P_PYD: begin mul_a = 48'(py_q);  mul_b = {2'b00, dv}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign prod     = mul_full[63:0];

  // truncation toward zero: bias negative values before the arithmetic shift
  assign pxs    = (64'(lhm_q) <<< 14) - tn_q;
  assign pys    = (64'(lhn_q) <<< 14) + tm_q;
  assign px_cut = 38'((pxs + (pxs[63] ? BIAS28 : 64'sd0)) >>> 28);
  assign py_cut = 38'((pys + (pys[63] ? BIAS28 : 64'sd0)) >>> 28);

  // 30*v = 32v - 2v, 15*v = 16v - v
  assign xs    = (64'sd40 <<< 44) + (64'(pxd_q) <<< 5) - (64'(pxd_q) <<< 1);
  assign ys    = (64'sd12 <<< 44) + (64'(pyd_q) <<< 4) - 64'(pyd_q);
  assign x_cut = 16'((xs + (xs[63] ? BIAS44 : 64'sd0)) >>> 44);
  assign y_cut = 16'((ys + (ys[63] ? BIAS44 : 64'sd0)) >>> 44);

  assign lsum = am_q - (64'(cde_q) <<< 14) - (64'(fg_q) <<< 28) - (64'(ldn_q) <<< 14);
  assign lq   = (lsum_q + (lsum_q[63] ? BIAS53 : 64'sd0)) >>> 53;

  assign den_u = REM_W'($unsigned(den_q));
  assign r2    = {rem_q[REM_W-2:0], 1'b0};
  assign dv    = sat_q ? 16'hFFFF : q_q;

  assign x_ok   = !x_q[15] && (x_q != 16'sd0) && (x_q < 16'(COLUMNS));
  assign y_ok   = !y_q[15] && (y_q != 16'sd0) && (y_q < 16'(ROWS));
  assign o_comb = AW'(x_q) + AW'(32'(y_q) * COLUMNS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q      <= command_i;
      c_q        <= sin_theta_i;
      l_q        <= cos_theta_i;
      f_q        <= sin_phi_i;
      d_q        <= cos_phi_i;
      e_q        <= sin_rot_a_i;
      g_q        <= cos_rot_a_i;
      n_q        <= sin_rot_b_i;
      m_q        <= cos_rot_b_i;
      idx_q      <= cell_index_i;
      res_char_q <= '0;
      res_wr_q   <= 1'b0;
    end
    case (cmd_i.step)
      tzp_pkg::P_CH:  ch_q  <= 32'(prod);
      tzp_pkg::P_CHE: che_q <= 48'(prod);
      tzp_pkg::P_CHG: chg_q <= 48'(prod);
      tzp_pkg::P_FG:  fg_q  <= 32'(prod);
      tzp_pkg::P_FE:  fe_q  <= 32'(prod);
      tzp_pkg::P_DEN: begin
        den_q <= che_q + (48'(fg_q) <<< 14) + DEN_OFS;
        t_q   <= chg_q - (48'(fe_q) <<< 14);
      end
      tzp_pkg::P_LH:  lh_q  <= 32'(prod);
      tzp_pkg::P_LHM: lhm_q <= 48'(prod);
      tzp_pkg::P_LHN: lhn_q <= 48'(prod);
      tzp_pkg::P_TN:  tn_q  <= prod;
      tzp_pkg::P_TM:  tm_q  <= prod;
      tzp_pkg::P_PXY: begin
        px_q <= px_cut;
        py_q <= py_cut;
      end
      tzp_pkg::P_CD:  cd_q  <= 32'(prod);
      tzp_pkg::P_CDG: cdg_q <= 48'(prod);
      tzp_pkg::P_CDE: cde_q <= 48'(prod);
      tzp_pkg::P_LD:  ld_q  <= 32'(prod);
      tzp_pkg::P_LDN: ldn_q <= 48'(prod);
      tzp_pkg::P_A:   av_q  <= (48'(fe_q) <<< 14) - cdg_q;
      tzp_pkg::P_AM:  am_q  <= prod;
      tzp_pkg::P_LUM: lsum_q <= lsum;
      tzp_pkg::P_LUMC: begin
        if (lq[63])              lum_q <= 4'd0;
        else if (lq > 64'sd11)   lum_q <= 4'd11;
        else                     lum_q <= 4'(lq);
      end
      tzp_pkg::P_DIVI: begin
        // quotient below 2^16 only when den > 2^42; else it saturates
        rem_q     <= REM_W'(1) << 42;
        q_q       <= '0;
        sat_q     <= (den_q <= SAT_LIM);
        den_pos_q <= (den_q > 48'sd0);
      end
      tzp_pkg::P_DIV: begin
        if (r2 >= den_u) begin
          rem_q <= r2 - den_u;
          q_q   <= {q_q[14:0], 1'b1};
        end else begin
          rem_q <= r2;
          q_q   <= {q_q[14:0], 1'b0};
        end
      end
      tzp_pkg::P_PXD: pxd_q <= 56'(prod);
      tzp_pkg::P_PYD: pyd_q <= 56'(prod);
      tzp_pkg::P_XY: begin
        x_q <= x_cut;
        y_q <= y_cut;
      end
      tzp_pkg::P_RD: begin
        inb_q <= x_ok && y_ok && den_pos_q;
        o_q   <= o_comb;
      end
      tzp_pkg::P_WR: begin
        if (wr_en) res_wr_q <= 1'b1;
      end
      default: ;
    endcase
    if (cmd_i.take_cell) begin
      res_char_q <= (32'(idx_q) < CELLS) ? rd_q[7:0] : 8'd0;
    end
    if (cmd_i.load_out) begin
      out_char_q <= res_char_q;
      out_wr_q   <= res_wr_q;
    end
  end

  // frame memory: {depth, char} per cell
  assign rd_en   = (cmd_i.step == tzp_pkg::P_RD) || cmd_i.rd_cell;
  assign rd_addr = (cmd_i.step == tzp_pkg::P_RD) ? o_comb : AW'(idx_q);
  assign wr_en   = (cmd_i.step == tzp_pkg::P_WR) && inb_q && (dv > rd_q[23:8]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      mem[clr_addr_q] <= {16'd0, tzp_pkg::CHAR_SPACE};
    end else if (wr_en) begin
      mem[o_q] <= {dv, tzp_pkg::ramp_char(lum_q)};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_addr_q <= stat_o.clr_last ? '0 : clr_addr_q + AW'(1);
    end
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.clr_last = (clr_addr_q == AW'(CELLS - 1));

  assign cell_char_o     = out_char_q;
  assign point_written_o = out_wr_q;

endmodule

// ----- src/torus_point_zbuffer_plotter.sv -----
// ----------------------------------------------------------------------------
// torus_point_zbuffer_plotter: depth-buffered torus point plotter
// Plot sequence: 21 multiply/add steps, divider setup plus 16 iterations and
// 5 project/test/write steps. One item at a time; the shared multiplier and
// the one-bit-per-cycle reciprocal divider set the length of a plot.
// Reset: a clearing pass over all COLUMNS*ROWS cells fills the frame with
// spaces and zero depth; no item is accepted until it ends.
// ----------------------------------------------------------------------------
module torus_point_zbuffer_plotter #(
  parameter int COLUMNS = tzp_pkg::COLUMNS_DEF,
  parameter int ROWS    = tzp_pkg::ROWS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  tzp_in_if.sink    in_i,
  tzp_out_if.source out_o
);

  // control and status between sequencer and datapath
  tzp_pkg::tzp_cmd_t  cmd;
  tzp_pkg::tzp_stat_t stat;

  // sequencer: clear sweep, plot step list, reads, output register handshake
  tzp_controller u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: item capture, one multiplier, divider, frame memory, result regs
  tzp_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .command_i       (in_i.command),
    .sin_theta_i     (in_i.sin_theta),
    .cos_theta_i     (in_i.cos_theta),
    .sin_phi_i       (in_i.sin_phi),
    .cos_phi_i       (in_i.cos_phi),
    .sin_rot_a_i     (in_i.sin_rot_a),
    .cos_rot_a_i     (in_i.cos_rot_a),
    .sin_rot_b_i     (in_i.sin_rot_b),
    .cos_rot_b_i     (in_i.cos_rot_b),
    .cell_index_i    (in_i.cell_index),
    .cell_char_o     (out_o.cell_char),
    .point_written_o (out_o.point_written)
  );

endmodule

// ----- src/tzp_checker.sv -----
// ----------------------------------------------------------------------------
// tzp_checker: port-level checks of the torus point plotter
// Handshake behavior and result consistency, bound to the top level.
// ----------------------------------------------------------------------------
module tzp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] cell_char_i,
  input logic       point_written_i
);

  // one item in flight: ready drops right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while an item is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(cell_char_i) && $stable(point_written_i)))
    else $error("result changed while stalled");

  // a result is either a read or a plot, never both
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(point_written_i && (cell_char_i != 8'd0)))
    else $error("read char and plot flag both set");

endmodule

bind torus_point_zbuffer_plotter tzp_checker u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .cell_char_i     (out_o.cell_char),
  .point_written_i (out_o.point_written)
);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench of torus_point_zbuffer_plotter
// Drives clear, plot, read and no-op items through the valid/ready channels,
// predicts every result from an own model of the frame and depth buffer,
// and compares each result item field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COLS  = tzp_pkg::COLUMNS_DEF;
  localparam int ROWSN = tzp_pkg::ROWS_DEF;
  localparam int CELLS = COLS * ROWSN;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int LIMIT = 2_000_000;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] st, ct, sp, cp, sa, ca, sb, cb;
    logic [10:0]        cell_index;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic       point_written;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tzp_in_if  in_ch ();
  tzp_out_if out_ch ();

  torus_point_zbuffer_plotter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: our own copy of the frame
  logic [15:0] depth_mem [CELLS];
  logic [7:0]  char_mem  [CELLS];

  cmd_item_t pending_q [$];
  result_t   expected_q [$];
  int        errors;
  int        cycle_cnt;
  bit        sender_idle_en;    // random gaps on the input side
  bit        sink_idle_en;      // random stalls on the output side
  bit        hold_sink;         // long stall requested
  int        hold_cnt;
  bit        pause_sender;

  function automatic logic [7:0] shade(input int lum);
    case (lum)
      0: return ".";  1: return ",";  2: return "-";  3: return "~";
      4: return ":";  5: return ";";  6: return "=";  7: return "!";
      8: return "*";  9: return "#";  10: return "$";
      default: return "@";
    endcase
  endfunction

  // Plot of one surface point; all math exact in 64 bits, truncating divides.
  function automatic logic plot_point(input cmd_item_t it);
    longint c, l, f, d, e, g, n, m, h, den, dv, t, px, py, x, y, lum;
    longint one14;
    longint unsigned dq;
    int o;
    one14 = 16384;
    c = it.st; l = it.ct; f = it.sp; d = it.cp;
    e = it.sa; g = it.ca; n = it.sb; m = it.cb;
    h = d + 2 * one14;
    den = c * h * e + f * g * one14 + 5 * one14 * one14 * one14;
    if (den <= 0) return 1'b0;
    dq = (64'd1 << 58) / longint'(unsigned'(den));
    if (dq > 64'hFFFF) dq = 64'hFFFF;
    dv = longint'(dq);
    t  = c * h * g - f * e * one14;
    px = (l * h * m * one14 - t * n) / (64'sd1 << 28);
    py = (l * h * n * one14 + t * m) / (64'sd1 << 28);
    x  = (40 * (64'sd1 << 44) + 30 * dv * px) / (64'sd1 << 44);
    y  = (12 * (64'sd1 << 44) + 15 * dv * py) / (64'sd1 << 44);
    lum = ((f * e * one14 - c * d * g) * m - c * d * e * one14
           - f * g * one14 * one14 - l * d * n * one14) / (64'sd1 << 53);
    if (lum < 0) lum = 0;
    if (lum > 11) lum = 11;
    if (!(y > 0 && y < ROWSN && x > 0 && x < COLS)) return 1'b0;
    o = int'(x) + COLS * int'(y);
    if (dq[15:0] <= depth_mem[o]) return 1'b0;
    depth_mem[o] = dq[15:0];
    char_mem[o]  = shade(int'(lum));
    return 1'b1;
  endfunction

  function automatic void clear_frame();
    for (int i = 0; i < CELLS; i++) begin
      depth_mem[i] = '0;
      char_mem[i]  = tzp_pkg::CHAR_SPACE;
    end
  endfunction

  function automatic result_t frame_response(input cmd_item_t it);
    result_t r;
    r = '0;
    case (it.command)
      tzp_pkg::CMD_CLEAR: clear_frame();
      tzp_pkg::CMD_PLOT:  r.point_written = plot_point(it);
      tzp_pkg::CMD_READ:  if (it.cell_index < CELLS) r.cell_char = char_mem[it.cell_index];
      default: ;
    endcase
    return r;
  endfunction

  // Q2.14 value: mostly within +-1.0, sometimes full 16-bit range
  function automatic logic signed [15:0] rand_q14();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic cmd_item_t rand_plot();
    cmd_item_t it;
    int ang;
    it = '0;
    it.command = tzp_pkg::CMD_PLOT;
    it.st = rand_q14(); it.ct = rand_q14(); it.sp = rand_q14(); it.cp = rand_q14();
    it.sa = rand_q14(); it.ca = rand_q14(); it.sb = rand_q14(); it.cb = rand_q14();
    // most points use consistent sine/cosine pairs so they land in the frame
    if ($urandom_range(0, 3) != 0) begin
      ang = $urandom_range(0, 359);
      it.st = 16'($rtoi(16384.0 * $sin(ang * 3.14159265 / 180.0)));
      it.ct = 16'($rtoi(16384.0 * $cos(ang * 3.14159265 / 180.0)));
      ang = $urandom_range(0, 359);
      it.sp = 16'($rtoi(16384.0 * $sin(ang * 3.14159265 / 180.0)));
      it.cp = 16'($rtoi(16384.0 * $cos(ang * 3.14159265 / 180.0)));
      ang = $urandom_range(0, 359);
      it.sa = 16'($rtoi(16384.0 * $sin(ang * 3.14159265 / 180.0)));
      it.ca = 16'($rtoi(16384.0 * $cos(ang * 3.14159265 / 180.0)));
      ang = $urandom_range(0, 359);
      it.sb = 16'($rtoi(16384.0 * $sin(ang * 3.14159265 / 180.0)));
      it.cb = 16'($rtoi(16384.0 * $cos(ang * 3.14159265 / 180.0)));
    end
    it.cell_index = 11'($urandom);
    return it;
  endfunction

  function automatic cmd_item_t mk_item(input logic [1:0] cmd, input logic [10:0] idx);
    cmd_item_t it;
    it = '0;
    it.command    = cmd;
    it.cell_index = idx;
    return it;
  endfunction

  function automatic cmd_item_t mk_plot(input logic signed [15:0] st, ct, sp, cp,
                                        sa, ca, sb, cb);
    cmd_item_t it;
    it = '0;
    it.command = tzp_pkg::CMD_PLOT;
    it.st = st; it.ct = ct; it.sp = sp; it.cp = cp;
    it.sa = sa; it.ca = ca; it.sb = sb; it.cb = cb;
    return it;
  endfunction

  // Driver: pops the pending queue, holds valid until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(frame_response(pending_q.pop_front()));
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_q.size() > 0 && !pause_sender &&
            !(sender_idle_en && $urandom_range(0, 99) < 35)) begin
          in_ch.valid      <= 1'b1;
          in_ch.command    <= pending_q[0].command;
          in_ch.sin_theta  <= pending_q[0].st;
          in_ch.cos_theta  <= pending_q[0].ct;
          in_ch.sin_phi    <= pending_q[0].sp;
          in_ch.cos_phi    <= pending_q[0].cp;
          in_ch.sin_rot_a  <= pending_q[0].sa;
          in_ch.cos_rot_a  <= pending_q[0].ca;
          in_ch.sin_rot_b  <= pending_q[0].sb;
          in_ch.cos_rot_b  <= pending_q[0].cb;
          in_ch.cell_index <= pending_q[0].cell_index;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Note: the driver reads pending_q[0] after the accepted item was popped, which
  // is the next item; the head stays in the queue until its own acceptance.

  // Monitor and receiver stall control
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.cell_char     = out_ch.cell_char;
        got.point_written = out_ch.point_written;
        if (expected_q.size() == 0) begin
          $error("unexpected result item: cell_char %0d point_written %0d",
                 got.cell_char, got.point_written);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.cell_char !== want.cell_char) begin
            $error("cell_char: expected %0d actual %0d", want.cell_char, got.cell_char);
            errors++;
          end
          if (got.point_written !== want.point_written) begin
            $error("point_written: expected %0d actual %0d",
                   want.point_written, got.point_written);
            errors++;
          end
        end
      end
      if (hold_sink && hold_cnt < 400) begin
        hold_cnt     <= hold_cnt + 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (!hold_sink) hold_cnt <= 0;
        out_ch.ready <= !(sink_idle_en && $urandom_range(0, 99) < 35);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int n;
    sender_idle_en = 1; sink_idle_en = 1; hold_sink = 0; pause_sender = 0;
    clear_frame();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reads of fresh frame, extremes, no-op, negative denominator
    pending_q.push_back(mk_item(tzp_pkg::CMD_READ, 11'd0));
    pending_q.push_back(mk_item(tzp_pkg::CMD_READ, 11'(CELLS - 1)));
    pending_q.push_back(mk_item(tzp_pkg::CMD_READ, 11'(CELLS)));      // outside the frame
    pending_q.push_back(mk_item(tzp_pkg::CMD_READ, 11'h7FF));
    pending_q.push_back(mk_item(CMD_NOP, 11'h7FF));
    pending_q.push_back(mk_plot(16'sd0, 16'sd16384, 16'sd0, 16'sd16384,
                                16'sd0, 16'sd16384, 16'sd0, 16'sd16384));
    pending_q.push_back(mk_plot(16'sd0, 16'sd16384, 16'sd0, 16'sd16384,
                                16'sd0, 16'sd16384, 16'sd0, 16'sd16384)); // same depth
    pending_q.push_back(mk_plot(16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
                                16'sd16384, 16'sd0, 16'sd16384, 16'sd0));
    pending_q.push_back(mk_plot(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
                                -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384));
    // denominator driven to zero or below
    pending_q.push_back(mk_plot(16'sh7FFF, 16'sd0, 16'sh8000, 16'sh7FFF,
                                16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0));
    // h is zero here: denominator 9 * 2^42, so the depth does not saturate
    pending_q.push_back(mk_plot(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                                16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF));
    pending_q.push_back(mk_plot(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                                16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF));
    for (int i = 0; i < 6; i++) pending_q.push_back(rand_plot());
    pending_q.push_back(mk_item(tzp_pkg::CMD_READ, 11'(COLS * 12 + 40)));
    pending_q.push_back(mk_item(tzp_pkg::CMD_CLEAR, 11'h7FF));
    pending_q.push_back(mk_item(tzp_pkg::CMD_READ, 11'(COLS * 12 + 40)));

    // Random part, in batches; the pressure phases sit between batches
    n = 0;
    while (n < 1750) begin
      for (int k = 0; k < 50; k++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) pending_q.push_back(rand_plot());
        else if (r < 95) pending_q.push_back(mk_item(tzp_pkg::CMD_READ,
                                 11'($urandom_range(0, 99) < 3 ? $urandom_range(CELLS, 2047)
                                                              : $urandom_range(0, CELLS - 1))));
        else if (r < 97) pending_q.push_back(mk_item(CMD_NOP, 11'($urandom)));
        else pending_q.push_back(mk_item(tzp_pkg::CMD_CLEAR, 11'($urandom)));
      end
      n += 50;
      wait (pending_q.size() < 10);
      if (n == 300) begin
        // long receiver stall while the sender keeps offering items
        hold_sink = 1;
        wait (hold_cnt >= 400);
        hold_sink = 0;
      end
      if (n == 600) begin
        // sender waits until every result is back
        pause_sender = 1;
        wait (expected_q.size() == 0 && !in_ch.valid);
        repeat (5) @(posedge clk_i);
        pause_sender = 0;
      end
      if (n == 800) begin
        sender_idle_en = 0; sink_idle_en = 0;
      end
      if (n == 1100) begin
        sender_idle_en = 1; sink_idle_en = 1;
      end
    end

    wait (pending_q.size() == 0 && !in_ch.valid);
    wait (expected_q.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tzp_pkg.sv
src/tzp_if.sv
src/tzp_controller.sv
src/tzp_datapath.sv
src/torus_point_zbuffer_plotter.sv
src/tzp_checker.sv
bench/testbench.sv
